[design/corner_color_bilinear_gradient_macros.svh]
`ifndef CORNER_COLOR_BILINEAR_GRADIENT_MACROS_SVH
`define CORNER_COLOR_BILINEAR_GRADIENT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CCBG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ccbg check failed");

// Next-cycle implication.
`define CCBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ccbg check failed");

`endif

[design/ccbg_pkg.sv]
`default_nettype none

package ccbg_pkg;

	localparam int MAX_GRID        = 1024;
	localparam int COMP_BITS       = 16;
	localparam int LANES           = 4;
	localparam int LANE_STRIDE     = 16;
	localparam int COORD_BITS      = 10;
	localparam int SIZE_BITS       = 11;
	localparam int IDX_BITS        = 20;
	localparam int QUO_BITS        = 16;
	localparam int WGT_BITS        = QUO_BITS + 1;
	localparam int DIV_STAGES      = 4;
	localparam int STEPS_PER_STAGE = QUO_BITS / DIV_STAGES;
	localparam int PROD_BITS       = 35;
	localparam int NSTAGES         = 9;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CORNER_BITS     = LANES * LANE_STRIDE;

	localparam logic [WGT_BITS-1:0]  WONE  = WGT_BITS'(1) << QUO_BITS;
	localparam logic [COMP_BITS-1:0] CMASK = {COMP_BITS{1'b1}};

	localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_A = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_B = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_C = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_D = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_COLUMNS  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ROWS     = 3'd5;

	typedef logic [COMP_BITS-1:0]        comp_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]   idx;
		logic [COORD_BITS-1:0] rx;
		logic [COORD_BITS-1:0] ry;
		logic [QUO_BITS-1:0]   qx;
		logic [QUO_BITS-1:0]   qy;
		logic                  satx;
		logic                  saty;
	} div_t;

	function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] n);
		if (n < SIZE_BITS'(2))
			return SIZE_BITS'(2);
		if (n > SIZE_BITS'(MAX_GRID))
			return SIZE_BITS'(MAX_GRID);
		return n;
	endfunction

	function automatic comp_t lane(input logic [CORNER_BITS-1:0] packed_c, input int k);
		return packed_c[k*LANE_STRIDE +: COMP_BITS] & CMASK;
	endfunction

	// One restoring step per quotient bit; remainder stays below the divisor.
	function automatic div_t div_steps(input div_t d, input logic [COORD_BITS-1:0] lx,
			input logic [COORD_BITS-1:0] ly);
		div_t o;
		logic [COORD_BITS:0] sh;
		o = d;
		for (int i = 0; i < STEPS_PER_STAGE; i++) begin
			sh = {o.rx, 1'b0};
			if (sh >= {1'b0, lx}) begin
				o.rx = COORD_BITS'(sh - {1'b0, lx});
				o.qx = {o.qx[QUO_BITS-2:0], 1'b1};
			end else begin
				o.rx = sh[COORD_BITS-1:0];
				o.qx = {o.qx[QUO_BITS-2:0], 1'b0};
			end
			sh = {o.ry, 1'b0};
			if (sh >= {1'b0, ly}) begin
				o.ry = COORD_BITS'(sh - {1'b0, ly});
				o.qy = {o.qy[QUO_BITS-2:0], 1'b1};
			end else begin
				o.ry = sh[COORD_BITS-1:0];
				o.qy = {o.qy[QUO_BITS-2:0], 1'b0};
			end
		end
		return o;
	endfunction

	// (b - a) * t, signed; the blend is a + round(product / 2^16).
	function automatic prod_t lerp_prod(input comp_t a, input comp_t b,
			input logic [WGT_BITS-1:0] t);
		logic signed [COMP_BITS:0] diff;
		logic signed [WGT_BITS:0]  ts;
		diff = $signed({1'b0, b}) - $signed({1'b0, a});
		ts   = $signed({1'b0, t});
		return prod_t'(diff) * prod_t'(ts);
	endfunction

	function automatic comp_t lerp_fin(input comp_t a, input prod_t p);
		prod_t r;
		r = (p + prod_t'(32768)) >>> QUO_BITS;
		r = r + $signed({{(PROD_BITS-COMP_BITS){1'b0}}, a});
		return r[COMP_BITS-1:0] & CMASK;
	endfunction

endpackage

`default_nettype wire

[design/ccbg_ifs.sv]
`default_nettype none

interface ccbg_req_if import ccbg_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] column;
	logic [COORD_BITS-1:0] row;

	modport source (output valid, column, row, input ready);
	modport sink (input valid, column, row, output ready);
endinterface

interface ccbg_rsp_if import ccbg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [IDX_BITS-1:0] vertex_index;
	comp_t               red;
	comp_t               green;
	comp_t               blue;
	comp_t               alpha;

	modport source (output valid, vertex_index, red, green, blue, alpha, input ready);
	modport sink (input valid, vertex_index, red, green, blue, alpha, output ready);
endinterface

interface ccbg_cfg_if import ccbg_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [CORNER_BITS-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/corner_color_bilinear_gradient.sv]
// Channel   Dir   Word
// req       in    column, row
// rsp       out   vertex_index, red, green, blue, alpha
// cfg       in    index, data (register write)
//
// One vertex per clock while rsp is ready; a word accepted on req passes
// through nine register stages: a coordinate saturation stage, then the
// weight divider (4 stages of 4 quotient bits each) and the two lerp passes
// (multiply stage, then round-and-add stage each), before it shows on rsp.
// Each stage holds its word while the next one is full and stalled, so bubbles close up.
// Reset clears valid bits and corners, sets columns and rows to 2; no clearing pass.
`default_nettype none
`include "corner_color_bilinear_gradient_macros.svh"

module corner_color_bilinear_gradient import ccbg_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	ccbg_req_if.sink   req,
	ccbg_rsp_if.source rsp,
	ccbg_cfg_if.sink   cfg
);

	logic [CORNER_BITS-1:0] corner_a_q, corner_b_q, corner_c_q, corner_d_q;
	logic [SIZE_BITS-1:0]   columns_q, rows_q;

	logic [SIZE_BITS-1:0]  cols, rows;
	logic [COORD_BITS-1:0] lastx, lasty;

	logic [NSTAGES:1] vld_s;
	logic [NSTAGES:1] en;

	logic [COORD_BITS-1:0] cx_s1, cy_s1;
	logic                  satx_s1, saty_s1;

	div_t dv_s  [2:5];
	div_t dv_nx [2:5];

	logic [WGT_BITS-1:0] tx, ty;
	logic [IDX_BITS-1:0] idx_s6, idx_s7, idx_s8, idx_s9;
	logic [WGT_BITS-1:0] ty_s6, ty_s7;
	prod_t               ptop_s6 [LANES];
	prod_t               pbot_s6 [LANES];
	comp_t               top_s7 [LANES];
	comp_t               bot_s7 [LANES];
	comp_t               top_s8 [LANES];
	prod_t               pcol_s8 [LANES];
	comp_t               col_s9 [LANES];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_a_q <= '0;
			corner_b_q <= '0;
			corner_c_q <= '0;
			corner_d_q <= '0;
			columns_q  <= SIZE_BITS'(2);
			rows_q     <= SIZE_BITS'(2);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CORNER_A: corner_a_q <= cfg.data;
				REG_CORNER_B: corner_b_q <= cfg.data;
				REG_CORNER_C: corner_c_q <= cfg.data;
				REG_CORNER_D: corner_d_q <= cfg.data;
				REG_COLUMNS:  columns_q  <= cfg.data[SIZE_BITS-1:0];
				REG_ROWS:     rows_q     <= cfg.data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cols  = clamp_size(columns_q);
	assign rows  = clamp_size(rows_q);
	assign lastx = COORD_BITS'(cols - SIZE_BITS'(1));
	assign lasty = COORD_BITS'(rows - SIZE_BITS'(1));

	// A stage loads when it is empty or its word moves on this cycle.
	always_comb begin
		en[NSTAGES] = !vld_s[NSTAGES] || rsp.ready;
		for (int k = NSTAGES - 1; k >= 1; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign req.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1])
				vld_s[1] <= req.valid;
			for (int k = 2; k <= NSTAGES; k++)
				if (en[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	// Stage 1: saturate coordinates to the last vertex.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			satx_s1 <= req.column >= lastx;
			saty_s1 <= req.row >= lasty;
			cx_s1   <= (req.column >= lastx) ? lastx : req.column;
			cy_s1   <= (req.row >= lasty) ? lasty : req.row;
		end
	end

	// Stages 2..5: long division coord * 2^16 / last, four quotient bits each.
	always_comb begin
		div_t d0;
		d0.idx  = '0;
		d0.rx   = cx_s1;
		d0.ry   = cy_s1;
		d0.qx   = '0;
		d0.qy   = '0;
		d0.satx = satx_s1;
		d0.saty = saty_s1;
		dv_nx[2] = div_steps(d0, lastx, lasty);
		dv_nx[2].idx = IDX_BITS'(cy_s1) * IDX_BITS'(cols) + IDX_BITS'(cx_s1);
		for (int k = 3; k <= 5; k++)
			dv_nx[k] = div_steps(dv_s[k-1], lastx, lasty);
	end

	always_ff @(posedge clk) begin
		for (int k = 2; k <= 5; k++)
			if (en[k])
				dv_s[k] <= dv_nx[k];
	end

	assign tx = dv_s[5].satx ? WONE : {1'b0, dv_s[5].qx};
	assign ty = dv_s[5].saty ? WONE : {1'b0, dv_s[5].qy};

	// Stages 6..7: blend A to B and C to D along x.
	always_ff @(posedge clk) begin
		if (en[6]) begin
			idx_s6 <= dv_s[5].idx;
			ty_s6  <= ty;
			for (int k = 0; k < LANES; k++) begin
				ptop_s6[k] <= lerp_prod(lane(corner_a_q, k), lane(corner_b_q, k), tx);
				pbot_s6[k] <= lerp_prod(lane(corner_c_q, k), lane(corner_d_q, k), tx);
			end
		end
		if (en[7]) begin
			idx_s7 <= idx_s6;
			ty_s7  <= ty_s6;
			for (int k = 0; k < LANES; k++) begin
				top_s7[k] <= lerp_fin(lane(corner_a_q, k), ptop_s6[k]);
				bot_s7[k] <= lerp_fin(lane(corner_c_q, k), pbot_s6[k]);
			end
		end
	end

	// Stages 8..9: blend top to bottom along y.
	always_ff @(posedge clk) begin
		if (en[8]) begin
			idx_s8 <= idx_s7;
			for (int k = 0; k < LANES; k++) begin
				top_s8[k]  <= top_s7[k];
				pcol_s8[k] <= lerp_prod(top_s7[k], bot_s7[k], ty_s7);
			end
		end
		if (en[9]) begin
			idx_s9 <= idx_s8;
			for (int k = 0; k < LANES; k++)
				col_s9[k] <= lerp_fin(top_s8[k], pcol_s8[k]);
		end
	end

	assign rsp.valid        = vld_s[NSTAGES];
	assign rsp.vertex_index = idx_s9;
	assign rsp.red          = col_s9[0];
	assign rsp.green        = col_s9[1];
	assign rsp.blue         = col_s9[2];
	assign rsp.alpha        = col_s9[3];

	`CCBG_ASSERT_NOW(a_empty_out_accepts, clk, arst_n, !vld_s[NSTAGES], en[1])
	`CCBG_ASSERT_NEXT(a_out_held, clk, arst_n, vld_s[NSTAGES] && !rsp.ready,
		vld_s[NSTAGES])
	`CCBG_ASSERT_NOW(a_div_rem_x, clk, arst_n, vld_s[5] && !dv_s[5].satx,
		dv_s[5].rx < lastx)

endmodule

`default_nettype wire

[bench/tb_corner_color_bilinear_gradient.sv]
`default_nettype none

module tb_corner_color_bilinear_gradient;
	timeunit 1ns;
	timeprecision 1ps;

	import ccbg_pkg::*;

	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [IDX_BITS-1:0] vertex_index;
		comp_t [LANES-1:0]   rgba;
	} vertex_color_t;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	ccbg_req_if req_ch ();
	ccbg_rsp_if rsp_ch ();
	ccbg_cfg_if cfg_ch ();

	corner_color_bilinear_gradient dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Register image used for prediction
	logic [CORNER_BITS-1:0] corner_a, corner_b, corner_c, corner_d;
	logic [SIZE_BITS-1:0]   columns_reg, rows_reg;

	vertex_color_t expected_colors [$];
	int            mismatches   = 0;
	int            results_seen = 0;
	bit            send_steady  = 1'b0;
	bit            take_steady  = 1'b0;

	function automatic int gap_len(bit steady);
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic longint unsigned size_used(logic [SIZE_BITS-1:0] n);
		if (n < 2)
			return 2;
		if (n > MAX_GRID)
			return MAX_GRID;
		return n;
	endfunction

	// Pin the coordinate to the last vertex and give full weight there.
	function automatic longint unsigned axis_weight(inout longint unsigned coord,
			input longint unsigned n);
		if (coord >= n - 1) begin
			coord = n - 1;
			return longint'(1) << QUO_BITS;
		end
		return (coord << QUO_BITS) / (n - 1);
	endfunction

	function automatic longint unsigned mix(longint unsigned a, longint unsigned b,
			longint unsigned t);
		return (a * ((longint'(1) << QUO_BITS) - t) + b * t
			+ (longint'(1) << (QUO_BITS - 1))) >> QUO_BITS;
	endfunction

	function automatic vertex_color_t shade_vertex(logic [COORD_BITS-1:0] col,
			logic [COORD_BITS-1:0] row);
		longint unsigned ncols, nrows, cx, cy, tx, ty, top, bot;
		vertex_color_t v;
		ncols = size_used(columns_reg);
		nrows = size_used(rows_reg);
		cx = col;
		cy = row;
		tx = axis_weight(cx, ncols);
		ty = axis_weight(cy, nrows);
		v.vertex_index = IDX_BITS'(cy * ncols + cx);
		for (int k = 0; k < LANES; k++) begin
			top = mix(corner_a[k*LANE_STRIDE +: COMP_BITS],
				corner_b[k*LANE_STRIDE +: COMP_BITS], tx);
			bot = mix(corner_c[k*LANE_STRIDE +: COMP_BITS],
				corner_d[k*LANE_STRIDE +: COMP_BITS], tx);
			v.rgba[k] = COMP_BITS'(mix(top, bot, ty));
		end
		return v;
	endfunction

	function automatic logic [CORNER_BITS-1:0] pick_corner();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// Size word with random upper bits; the block keeps only the low field.
	function automatic logic [CORNER_BITS-1:0] size_word();
		logic [CORNER_BITS-1:0] w;
		int r;
		w = {$urandom, $urandom};
		r = $urandom_range(0, 99);
		if (r < 10)
			w[SIZE_BITS-1:0] = SIZE_BITS'($urandom_range(0, 1));
		else if (r < 20)
			w[SIZE_BITS-1:0] = SIZE_BITS'($urandom_range(MAX_GRID + 1, (1 << SIZE_BITS) - 1));
		else if (r < 30)
			w[SIZE_BITS-1:0] = SIZE_BITS'(MAX_GRID);
		else if (r < 40)
			w[SIZE_BITS-1:0] = 2;
		else if (r < 60)
			w[SIZE_BITS-1:0] = SIZE_BITS'($urandom_range(3, 16));
		else
			w[SIZE_BITS-1:0] = SIZE_BITS'($urandom_range(2, MAX_GRID));
		return w;
	endfunction

	function automatic logic [COORD_BITS-1:0] pick_coord(logic [SIZE_BITS-1:0] n);
		longint unsigned last;
		int r;
		last = size_used(n) - 1;
		r = $urandom_range(0, 99);
		if (r < 15)
			return COORD_BITS'(last);
		if (r < 25)
			return '0;
		if (r < 75)
			return COORD_BITS'($urandom_range(0, last));
		return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
	endfunction

	task automatic send_vertex(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row);
		int gap;
		gap = gap_len(send_steady);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.column <= col;
		req_ch.row    <= row;
		do @(posedge clk); while (!req_ch.ready);
		expected_colors.push_back(shade_vertex(col, row));
	endtask

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CORNER_BITS-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_CORNER_A: corner_a = value;
			REG_CORNER_B: corner_b = value;
			REG_CORNER_C: corner_c = value;
			REG_CORNER_D: corner_d = value;
			REG_COLUMNS:  columns_reg = value[SIZE_BITS-1:0];
			REG_ROWS:     rows_reg = value[SIZE_BITS-1:0];
			default: ;
		endcase
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drop valid, then hold until every pending word has come back.
	task automatic drain_pipe();
		req_ch.valid <= 1'b0;
		while (expected_colors.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic test_reset_state();
		send_vertex(0, 0);
		send_vertex(1, 1);
		send_vertex(1023, 1023);
		drain_pipe();
	endtask

	task automatic test_full_range_corners();
		write_reg(REG_CORNER_A, '0);
		write_reg(REG_CORNER_B, '1);
		write_reg(REG_CORNER_C, 64'h8000_7FFF_0001_FFFE);
		write_reg(REG_CORNER_D, 64'h1234_FFFF_FFFF_5555);
		write_reg(REG_COLUMNS, 64'hFFFF_FFFF_FFFF_F400);
		write_reg(REG_ROWS, 64'h0000_0000_0000_0400);
		send_vertex(0, 0);
		send_vertex(1023, 0);
		send_vertex(0, 1023);
		send_vertex(1023, 1023);
		send_vertex(511, 512);
		send_vertex(1022, 1);
		drain_pipe();
	endtask

	// Half-way weights land exactly on .5 and must round up.
	task automatic test_half_rounding();
		write_reg(REG_CORNER_A, '0);
		write_reg(REG_CORNER_B, 64'h0001_0001_0001_0001);
		write_reg(REG_CORNER_C, 64'h0001_0000_0001_0000);
		write_reg(REG_CORNER_D, '0);
		write_reg(REG_COLUMNS, 3);
		write_reg(REG_ROWS, 3);
		send_vertex(1, 0);
		send_vertex(1, 1);
		send_vertex(2, 1);
		drain_pipe();
	endtask

	task automatic test_beyond_grid();
		write_reg(REG_CORNER_A, 64'h0F0F_F0F0_AAAA_5555);
		write_reg(REG_CORNER_D, 64'hFFFF_0000_1357_9BDF);
		write_reg(REG_COLUMNS, 64'hABCD_0000_0000_0005);
		write_reg(REG_ROWS, 3);
		send_vertex(4, 2);
		send_vertex(7, 9);
		send_vertex(1023, 1023);
		send_vertex(3, 1);
		drain_pipe();
	endtask

	task automatic test_size_limits();
		write_reg(REG_COLUMNS, 0);
		write_reg(REG_ROWS, 64'h0000_0000_0000_07FF);
		send_vertex(1, 5);
		send_vertex(0, 1023);
		send_vertex(700, 1022);
		drain_pipe();
		write_reg(REG_COLUMNS, 1025);
		write_reg(REG_ROWS, 1);
		send_vertex(1023, 1);
		drain_pipe();
	endtask

	task automatic test_unknown_register();
		write_reg(REG_COLUMNS, 37);
		write_reg(REG_ROWS, 19);
		write_reg(REG_UNUSED_LO, '1);
		write_reg(REG_UNUSED_HI, {$urandom, $urandom});
		send_vertex(2, 3);
		send_vertex(1023, 0);
		send_vertex(0, 0);
		drain_pipe();
	endtask

	task automatic test_random_phases();
		for (int p = 0; p < 15; p++) begin
			send_steady = ($urandom_range(0, 3) == 0);
			take_steady = ($urandom_range(0, 3) == 0);
			write_reg(REG_CORNER_A, pick_corner());
			write_reg(REG_CORNER_B, pick_corner());
			write_reg(REG_CORNER_C, pick_corner());
			write_reg(REG_CORNER_D, pick_corner());
			write_reg(REG_COLUMNS, size_word());
			write_reg(REG_ROWS, size_word());
			if ($urandom_range(0, 3) == 0)
				write_reg($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI,
					{$urandom, $urandom});
			for (int i = 0; i < 128; i++)
				send_vertex(pick_coord(columns_reg), pick_coord(rows_reg));
			drain_pipe();
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.column <= '0;
		req_ch.row    <= '0;
		cfg_ch.valid  <= 1'b0;
		cfg_ch.index  <= '0;
		cfg_ch.data   <= '0;
		corner_a      = '0;
		corner_b      = '0;
		corner_c      = '0;
		corner_d      = '0;
		columns_reg   = 2;
		rows_reg      = 2;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_full_range_corners();
		test_half_rounding();
		test_beyond_grid();
		test_size_limits();
		test_unknown_register();
		test_random_phases();

		if (mismatches == 0 && expected_colors.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Output back-pressure
	initial begin
		int n;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = gap_len(take_steady);
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : check_results
		vertex_color_t got, want;
		bit bad;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.vertex_index = rsp_ch.vertex_index;
			got.rgba = {rsp_ch.alpha, rsp_ch.blue, rsp_ch.green, rsp_ch.red};
			if (expected_colors.size() == 0) begin
				if (mismatches < 10)
					$display("word %0d arrived with nothing pending: idx=%0d rgba=%h",
						results_seen, got.vertex_index, got.rgba);
				mismatches++;
			end else begin
				want = expected_colors.pop_front();
				bad = (got.vertex_index !== want.vertex_index);
				for (int k = 0; k < LANES; k++)
					if (got.rgba[k] !== want.rgba[k])
						bad = 1'b1;
				if (bad) begin
					if (mismatches < 10)
						$display("word %0d differs: want idx=%0d r=%h g=%h b=%h a=%h, got idx=%0d r=%h g=%h b=%h a=%h",
							results_seen, want.vertex_index, want.rgba[0], want.rgba[1],
							want.rgba[2], want.rgba[3], got.vertex_index, got.rgba[0],
							got.rgba[1], got.rgba[2], got.rgba[3]);
					mismatches++;
				end
			end
			results_seen++;
		end
	end

	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
